// ===== design/pcc_pkg.sv =====
package pcc_pkg;

    localparam int DATA_BITS_DEF      = 16;
    localparam int ROTATION_STEPS_DEF = 16;

    localparam int ZW = 34;

    localparam int UNITS_HALF = 23040;
    localparam int UNITS_FULL = 46080;

    localparam int MAG_LIMIT   = 46341;
    localparam int COORD_MAX   = 32767;
    localparam int COORD_MIN   = -32768;

    localparam logic signed [33:0] GAIN_Q32 = 34'sd2608131496;

    localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;

    localparam logic [31:0] PHASE_PER_UNIT = 32'd93206;
    localparam logic [20:0] PHASE_REM      = 21'd34;
    localparam logic [20:0] PHASE_BIAS     = 21'd22;
    localparam logic [42:0] RECIP_45       = 43'd2982617;
    localparam int          RECIP_SHIFT    = 27;

    typedef enum logic {
        OP_TO_POLAR = 1'b0,
        OP_TO_CART  = 1'b1
    } t_op;

    typedef struct packed {
        t_op  op;
        logic a_neg;
        logic b_neg;
        logic b_zero;
    } t_ctl;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== design/polar_cartesian_converter.sv =====
// The pipeline has three setup stages (gain multiply, angle scaling, quadrant fold),
// one cell per rotation step, and one rounding/output stage.
// Throughput: one word per cycle; every stage has its own valid and a ready chain,
// so stalls fill bubbles before back-pressure reaches the input.
// Reset: synchronous, active low; clears all stage valid flags, data is not reset.
module polar_cartesian_converter
    import pcc_pkg::*;
#(
    parameter int DATA_BITS      = DATA_BITS_DEF,
    parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // operand_a[15:0], operand_b[31:16]
    input  logic [0:0]  s_axis_tuser,  // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result_a[16:0], result_b[32:17], zero[39:33]
);

    localparam int W = DATA_BITS + 19;

    logic                 w_valid [0:ROTATION_STEPS];
    logic                 w_ready [0:ROTATION_STEPS];
    t_ctl                 w_ctl   [0:ROTATION_STEPS];
    logic signed [W-1:0]  w_x     [0:ROTATION_STEPS];
    logic signed [W-1:0]  w_y     [0:ROTATION_STEPS];
    logic signed [ZW-1:0] w_z     [0:ROTATION_STEPS];

    logic signed [16:0]   w_ra;
    logic signed [15:0]   w_rb;

    pcc_pre #(
        .DATA_BITS (DATA_BITS),
        .W         (W)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (t_op'(s_axis_tuser[0])),
        .i_a     ($signed(s_axis_tdata[15:0])),
        .i_b     ($signed(s_axis_tdata[31:16])),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_ctl   (w_ctl[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0])
    );

    for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
        pcc_cell #(
            .W    (W),
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    pcc_post #(
        .DATA_BITS (DATA_BITS),
        .W         (W)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[ROTATION_STEPS]),
        .o_ready (w_ready[ROTATION_STEPS]),
        .i_ctl   (w_ctl[ROTATION_STEPS]),
        .i_x     (w_x[ROTATION_STEPS]),
        .i_y     (w_y[ROTATION_STEPS]),
        .i_z     (w_z[ROTATION_STEPS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_ra    (w_ra),
        .o_rb    (w_rb)
    );

    assign m_axis_tdata = {7'd0, w_rb, w_ra};

endmodule

// ===== design/pcc_pre.sv =====
module pcc_pre
    import pcc_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF,
    parameter int W         = DATA_BITS_DEF + 19
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_op                 i_op,
    input  logic signed [15:0]  i_a,
    input  logic signed [15:0]  i_b,
    output logic                o_valid,
    input  logic                i_ready,
    output t_ctl                o_ctl,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    localparam int PW = 50;

    logic                r1_valid, r2_valid, r3_valid;
    logic                w_rdy1, w_rdy2, w_rdy3;

    logic signed [PW-1:0] w_prod_a, w_prod_b;
    logic signed [16:0]   w_b17, w_bw;
    logic [15:0]          w_n;
    t_ctl                 w_ctl;

    t_ctl                r1_ctl, r2_ctl, r3_ctl;
    logic signed [W-1:0] r1_x, r1_y, r2_x, r2_y, r3_x, r3_y;
    logic [15:0]         r1_n;
    logic [31:0]         r2_m;
    logic [15:0]         r2_q;
    logic signed [ZW-1:0] r3_z;

    logic [20:0]          w_v;
    logic [42:0]          w_qprod;
    logic signed [W-1:0]  n2_x, n2_y;
    logic [32:0]          w_sum;
    logic signed [ZW-1:0] w_z0;
    logic signed [ZW-1:0] n3_z;
    logic signed [W-1:0]  n3_x, n3_y;

    assign w_rdy3  = !r3_valid || i_ready;
    assign w_rdy2  = !r2_valid || w_rdy3;
    assign w_rdy1  = !r1_valid || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_prod_a = i_a * GAIN_Q32;
    assign w_prod_b = i_b * GAIN_Q32;

    always_comb begin
        w_b17 = 17'(i_b);
        if (w_b17 >= UNITS_HALF) begin
            w_bw = w_b17 - 17'(UNITS_FULL);
        end else if (w_b17 < -UNITS_HALF) begin
            w_bw = w_b17 + 17'(UNITS_FULL);
        end else begin
            w_bw = w_b17;
        end
        w_n = 16'(w_bw + 17'(UNITS_HALF));
    end

    always_comb begin
        w_ctl.op     = i_op;
        w_ctl.a_neg  = i_a[15];
        w_ctl.b_neg  = i_b[15];
        w_ctl.b_zero = (i_b == 16'sd0);
    end

    always_comb begin
        w_v     = 21'(r1_n) * PHASE_REM + PHASE_BIAS;
        w_qprod = 43'(w_v) * RECIP_45;
        n2_x    = r1_x;
        n2_y    = r1_y;
        if (r1_ctl.op == OP_TO_POLAR && r1_ctl.a_neg) begin
            n2_x = -r1_x;
            n2_y = -r1_y;
        end
    end

    always_comb begin
        w_sum = 33'(r2_m) + 33'(r2_q);
        w_z0  = $signed(ZW'(w_sum)) - HALF_TURN;
        n3_x  = r2_x;
        n3_y  = r2_y;
        n3_z  = '0;
        if (r2_ctl.op == OP_TO_CART) begin
            n3_y = '0;
            n3_z = w_z0;
            if (w_z0 > QUARTER_TURN) begin
                n3_z = w_z0 - HALF_TURN;
                n3_x = -r2_x;
            end else if (w_z0 < -QUARTER_TURN) begin
                n3_z = w_z0 + HALF_TURN;
                n3_x = -r2_x;
            end
        end else if (r2_ctl.a_neg) begin
            n3_z = r2_ctl.b_neg ? -HALF_TURN : HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (w_rdy1) r1_valid <= i_valid;
            if (w_rdy2) r2_valid <= r1_valid;
            if (w_rdy3) r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_ctl <= w_ctl;
            r1_x   <= W'(w_prod_a >>> (32 - DATA_BITS));
            r1_y   <= W'(w_prod_b >>> (32 - DATA_BITS));
            r1_n   <= w_n;
        end
        if (w_rdy2 && r1_valid) begin
            r2_ctl <= r1_ctl;
            r2_x   <= n2_x;
            r2_y   <= n2_y;
            r2_m   <= 32'(r1_n) * PHASE_PER_UNIT;
            r2_q   <= 16'(w_qprod >> RECIP_SHIFT);
        end
        if (w_rdy3 && r2_valid) begin
            r3_ctl <= r2_ctl;
            r3_x   <= n3_x;
            r3_y   <= n3_y;
            r3_z   <= n3_z;
        end
    end

    assign o_valid = r3_valid;
    assign o_ctl   = r3_ctl;
    assign o_x     = r3_x;
    assign o_y     = r3_y;
    assign o_z     = r3_z;

endmodule

// ===== design/pcc_cell.sv =====
module pcc_cell
    import pcc_pkg::*;
#(
    parameter int W    = DATA_BITS_DEF + 19,
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_ctl                 i_ctl,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_ctl                 o_ctl,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic signed [ZW-1:0] o_z
);

    logic                 r_valid;
    t_ctl                 r_ctl;
    logic signed [W-1:0]  r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic signed [W-1:0]  w_dx, w_dy;
    logic signed [ZW-1:0] w_atan;
    logic                 w_ccw;

    assign o_ready = !r_valid || i_ready;

    assign w_dx   = i_y >>> STEP;
    assign w_dy   = i_x >>> STEP;
    assign w_atan = ZW'(atan_turn(5'(STEP)));
    assign w_ccw  = (i_ctl.op == OP_TO_CART) ? !i_z[ZW-1] : i_y[W-1];

    always_comb begin
        if (w_ccw) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - w_atan;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= i_ctl;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== design/pcc_post.sv =====
module pcc_post
    import pcc_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF,
    parameter int W         = DATA_BITS_DEF + 19
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_ctl                 i_ctl,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [16:0]   o_ra,
    output logic signed [15:0]   o_rb
);

    localparam logic signed [W:0] RoundHalf =
        {{(W - DATA_BITS + 1){1'b0}}, 1'b1, {(DATA_BITS - 1){1'b0}}};
    localparam logic signed [16:0] AngScale = 17'sd46080;

    logic                r_valid;
    logic signed [16:0]  r_ra, n_ra;
    logic signed [15:0]  r_rb, n_rb;

    logic signed [W:0]   w_xr, w_yr;
    logic signed [49:0]  w_tp;
    logic signed [17:0]  w_ang;

    assign o_ready = !r_valid || i_ready;

    assign w_xr  = ($signed({i_x[W-1], i_x}) + RoundHalf) >>> DATA_BITS;
    assign w_yr  = ($signed({i_y[W-1], i_y}) + RoundHalf) >>> DATA_BITS;
    assign w_tp  = i_z * AngScale;
    assign w_ang = 18'((w_tp + 50'sd2147483648) >>> 32);

    always_comb begin
        if (w_xr > MAG_LIMIT) begin
            n_ra = 17'(MAG_LIMIT);
        end else if (w_xr < -MAG_LIMIT) begin
            n_ra = 17'(-MAG_LIMIT);
        end else begin
            n_ra = 17'(w_xr);
        end

        if (i_ctl.op == OP_TO_CART) begin
            if (w_yr > COORD_MAX) begin
                n_rb = 16'(COORD_MAX);
            end else if (w_yr < COORD_MIN) begin
                n_rb = 16'(COORD_MIN);
            end else begin
                n_rb = 16'(w_yr);
            end
        end else if (i_ctl.b_zero) begin
            n_rb = i_ctl.a_neg ? 16'(UNITS_HALF) : 16'sd0;
        end else if (w_ang > UNITS_HALF) begin
            n_rb = 16'(UNITS_HALF);
        end else if (w_ang < -UNITS_HALF) begin
            n_rb = 16'(-UNITS_HALF);
        end else begin
            n_rb = 16'(w_ang);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ra <= n_ra;
            r_rb <= n_rb;
        end
    end

    assign o_valid = r_valid;
    assign o_ra    = r_ra;
    assign o_rb    = r_rb;

endmodule
